// ===== sv/fcn_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and character mapping functions of the font character normalizer
package fcn_pkg;

	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_GRAVE   = 8'h60;

	localparam logic [7:0] CP_LSQUOTE = 8'h91;
	localparam logic [7:0] CP_RSQUOTE = 8'h92;
	localparam logic [7:0] CP_LDQUOTE = 8'h93;
	localparam logic [7:0] CP_RDQUOTE = 8'h94;
	localparam logic [7:0] CP_ENDASH  = 8'h96;
	localparam logic [7:0] CP_EMDASH  = 8'h97;
	localparam logic [7:0] CP_ACUTE   = 8'hB4;

	localparam logic [7:0] U8_LEAD2   = 8'hC2;
	localparam logic [7:0] U8_LEAD3   = 8'hE2;
	localparam logic [7:0] U8_MID     = 8'h80;
	localparam logic [7:0] U8_LSQUOTE = 8'h98;
	localparam logic [7:0] U8_RSQUOTE = 8'h99;
	localparam logic [7:0] U8_LDQUOTE = 8'h9C;
	localparam logic [7:0] U8_RDQUOTE = 8'h9D;
	localparam logic [7:0] U8_ENDASH  = 8'h93;
	localparam logic [7:0] U8_EMDASH  = 8'h94;

	localparam logic [7:0] LOWER_A    = 8'h61;
	localparam logic [7:0] LOWER_Z    = 8'h7A;
	localparam logic [7:0] LAT_LO     = 8'hE0;
	localparam logic [7:0] LAT_LO_END = 8'hF6;
	localparam logic [7:0] LAT_HI     = 8'hF8;
	localparam logic [7:0] LAT_HI_END = 8'hFE;
	localparam logic [7:0] CASE_OFS   = 8'h20;

	localparam int GRP_MAX = 3;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_C2,
		HELD_E2,
		HELD_E2_80
	} held_t;

	// characters caused by one input byte, in output order
	typedef struct packed {
		logic [GRP_MAX-1:0][7:0] chars;
		logic [1:0]              cnt;
		logic                    last;
	} grp_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if ((c >= LOWER_A && c <= LOWER_Z) || (c >= LAT_LO && c <= LAT_LO_END) ||
			(c >= LAT_HI && c <= LAT_HI_END)) begin
			r = c - CASE_OFS;
		end
		return r;
	endfunction

	// zero when the byte is not a mapped punctuation byte
	function automatic logic [7:0] single_map(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			CP_LSQUOTE, CP_RSQUOTE, CP_ACUTE, CH_GRAVE: r = CH_APOS;
			CP_LDQUOTE, CP_RDQUOTE:                     r = CH_DQUOTE;
			CP_ENDASH, CP_EMDASH:                       r = CH_HYPHEN;
			default:                                    r = 8'h00;
		endcase
		return r;
	endfunction

	// zero when the byte does not end a three-byte sequence
	function automatic logic [7:0] tail_map(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			U8_LSQUOTE, U8_RSQUOTE: r = CH_APOS;
			U8_LDQUOTE, U8_RDQUOTE: r = CH_DQUOTE;
			U8_ENDASH, U8_EMDASH:   r = CH_HYPHEN;
			default:                r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] norm_byte(input logic [7:0] c);
		logic [7:0] m;
		m = single_map(c);
		return (m != 8'h00) ? m : fold_case(c);
	endfunction

endpackage

// ===== sv/fcn_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for input bytes and output characters
interface fcn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface fcn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// ===== sv/fcn_front.sv =====
`timescale 1ns / 1ps
// front end: accepts bytes, tracks held sequence bytes and forms character groups
module fcn_front (
	input  logic          clk,
	input  logic          arst_n,
	fcn_in_if.sink        in_ch,
	input  logic          q_ready,
	output logic          push,
	output fcn_pkg::grp_t push_grp
);

	fcn_pkg::held_t                   held_q;
	fcn_pkg::held_t                   held_d;
	logic                             accept;
	logic                             as_lead;
	logic [1:0]                       n;
	logic [7:0]                       tm;
	logic [fcn_pkg::GRP_MAX-1:0][7:0] chars;

	assign in_ch.ready = q_ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		chars   = '0;
		n       = 2'd0;
		as_lead = 1'b0;
		held_d  = fcn_pkg::HELD_NONE;
		tm      = fcn_pkg::tail_map(in_ch.in_byte);
		unique case (held_q)
			fcn_pkg::HELD_NONE: begin
				as_lead = 1'b1;
			end
			fcn_pkg::HELD_C2: begin
				n = 2'd1;
				if (in_ch.in_byte == fcn_pkg::CP_ACUTE) begin
					chars[0] = fcn_pkg::CH_APOS;
				end else begin
					chars[0] = fcn_pkg::fold_case(fcn_pkg::U8_LEAD2);
					as_lead  = 1'b1;
				end
			end
			fcn_pkg::HELD_E2: begin
				if (in_ch.in_byte == fcn_pkg::U8_MID && !in_ch.in_last) begin
					held_d = fcn_pkg::HELD_E2_80;
				end else begin
					chars[0] = fcn_pkg::fold_case(fcn_pkg::U8_LEAD3);
					n        = 2'd1;
					as_lead  = 1'b1;
				end
			end
			fcn_pkg::HELD_E2_80: begin
				if (tm != 8'h00) begin
					chars[0] = tm;
					n        = 2'd1;
				end else begin
					chars[0] = fcn_pkg::fold_case(fcn_pkg::U8_LEAD3);
					chars[1] = fcn_pkg::norm_byte(fcn_pkg::U8_MID);
					n        = 2'd2;
					as_lead  = 1'b1;
				end
			end
			default: begin
				as_lead = 1'b1;
			end
		endcase
		if (as_lead) begin
			if (in_ch.in_byte == fcn_pkg::U8_LEAD2 && !in_ch.in_last) begin
				held_d = fcn_pkg::HELD_C2;
			end else if (in_ch.in_byte == fcn_pkg::U8_LEAD3 && !in_ch.in_last) begin
				held_d = fcn_pkg::HELD_E2;
			end else begin
				chars[n] = fcn_pkg::norm_byte(in_ch.in_byte);
				n        = n + 2'd1;
			end
		end
	end

	assign push           = accept && (n != 2'd0);
	assign push_grp.chars = chars;
	assign push_grp.cnt   = n;
	assign push_grp.last  = in_ch.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= fcn_pkg::HELD_NONE;
		end else if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

// ===== sv/fcn_queue.sv =====
`timescale 1ns / 1ps
// short group queue between front end and output serializer
module fcn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcn_pkg::grp_t push_grp,
	output logic          q_ready,
	output logic          head_valid,
	output fcn_pkg::grp_t head_grp,
	input  logic          pop
);

	localparam logic [fcn_pkg::QCNT_W-1:0] FULL = fcn_pkg::QCNT_W'(fcn_pkg::QDEPTH);

	fcn_pkg::grp_t                    mem_q [fcn_pkg::QDEPTH];
	logic [fcn_pkg::QPTR_W-1:0]       wr_q;
	logic [fcn_pkg::QPTR_W-1:0]       rd_q;
	logic [fcn_pkg::QCNT_W-1:0]       count_q;

	assign q_ready    = count_q != FULL;
	assign head_valid = count_q != '0;
	assign head_grp   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/fcn_back.sv =====
`timescale 1ns / 1ps
// back end: serializes character groups into the output register
module fcn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  fcn_pkg::grp_t head_grp,
	output logic          pop,
	fcn_out_if.source     out_ch
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic       grp_end;

	assign load    = head_valid && (!valid_q || out_ch.ready);
	assign grp_end = idx_q == (head_grp.cnt - 2'd1);
	assign pop     = load && grp_end;

	assign out_ch.valid    = valid_q;
	assign out_ch.out_char = char_q;
	assign out_ch.out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= grp_end ? 2'd0 : idx_q + 2'd1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= head_grp.chars[idx_q];
			last_q <= head_grp.last && grp_end;
		end
	end

endmodule

// ===== sv/font_char_normalizer.sv =====
`timescale 1ns / 1ps
// top level of the font character normalizer
// Accepts one text byte per cycle while the four-entry group queue has room and emits
// normalized upper-case characters at one per cycle while the output is ready, through a
// registered output. A byte that completes or breaks a sequence gives one to three
// characters, which leave one after another; a byte held as part of a possible sequence
// gives none. With the queue empty, the first character of a byte passes through the group
// queue and then the output register.
module font_char_normalizer (
	input  logic      clk,
	input  logic      arst_n,
	fcn_in_if.sink    in_ch,
	fcn_out_if.source out_ch
);

	logic          q_ready;
	logic          push;
	fcn_pkg::grp_t push_grp;
	logic          head_valid;
	fcn_pkg::grp_t head_grp;
	logic          pop;

	fcn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_ready  (q_ready),
		.push     (push),
		.push_grp (push_grp)
	);

	fcn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (push_grp),
		.q_ready    (q_ready),
		.head_valid (head_valid),
		.head_grp   (head_grp),
		.pop        (pop)
	);

	fcn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_grp   (head_grp),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// ===== sv/fcn_checker.sv =====
`timescale 1ns / 1ps
// port checker for the font character normalizer output channel
module fcn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
		else $error("output payload changed while stalled");

	// every emitted letter is already folded to upper case
	a_no_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((out_char >= 8'h61 && out_char <= 8'h7A) ||
		(out_char >= 8'hE0 && out_char <= 8'hF6) || (out_char >= 8'hF8 && out_char <= 8'hFE)))
		else $error("lower-case character emitted");

	// mapped punctuation bytes never pass through
	a_no_punct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char != 8'h60 && out_char != 8'hB4 && out_char != 8'h91 &&
		out_char != 8'h92 && out_char != 8'h93 && out_char != 8'h94 &&
		out_char != 8'h96 && out_char != 8'h97))
		else $error("unmapped punctuation emitted");

endmodule

bind font_char_normalizer fcn_checker u_fcn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_char  (out_ch.out_char),
	.out_last  (out_ch.out_last)
);

// ===== verif/tb_font_char_normalizer.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the font character normalizer with random idling on both channels
module tb_font_char_normalizer;

	typedef struct packed {
		logic [7:0] code;
		logic       eot;
	} text_byte_t;

	typedef struct packed {
		logic [7:0] code;
		logic       eot;
	} font_char_t;

	localparam int CALM_TAIL = 40;

	logic clk = 1'b0;
	logic arst_n;

	fcn_in_if  in_if ();
	fcn_out_if out_if ();

	font_char_normalizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_byte_t text_bytes [$];
	font_char_t font_chars_due [$];
	logic [7:0] seq_bytes [2];
	int         seq_len = 0;
	int         total_bytes = 0;
	int         bytes_sent = 0;
	int         chars_seen = 0;
	int         errors = 0;
	int         src_gap = 0;
	int         snk_gap = 0;
	text_byte_t next_byte;
	font_char_t due;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		if ((c >= fcn_pkg::LOWER_A && c <= fcn_pkg::LOWER_Z) ||
			(c >= fcn_pkg::LAT_LO && c <= fcn_pkg::LAT_LO_END) ||
			(c >= fcn_pkg::LAT_HI && c <= fcn_pkg::LAT_HI_END)) begin
			return c - fcn_pkg::CASE_OFS;
		end
		return c;
	endfunction

	function automatic logic [7:0] punct_char(input logic [7:0] c);
		unique case (c)
			fcn_pkg::CP_LSQUOTE, fcn_pkg::CP_RSQUOTE, fcn_pkg::CP_ACUTE,
			fcn_pkg::CH_GRAVE: return fcn_pkg::CH_APOS;
			fcn_pkg::CP_LDQUOTE, fcn_pkg::CP_RDQUOTE: return fcn_pkg::CH_DQUOTE;
			fcn_pkg::CP_ENDASH, fcn_pkg::CP_EMDASH: return fcn_pkg::CH_HYPHEN;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] quote_tail(input logic [7:0] c);
		unique case (c)
			fcn_pkg::U8_LSQUOTE, fcn_pkg::U8_RSQUOTE: return fcn_pkg::CH_APOS;
			fcn_pkg::U8_LDQUOTE, fcn_pkg::U8_RDQUOTE: return fcn_pkg::CH_DQUOTE;
			fcn_pkg::U8_ENDASH, fcn_pkg::U8_EMDASH: return fcn_pkg::CH_HYPHEN;
			default: return 8'h00;
		endcase
	endfunction

	// expected characters for one accepted byte, held sequence updated
	task automatic normalize_byte(input logic [7:0] code, input logic eot);
		logic [7:0] seq [3];
		logic [7:0] m;
		font_char_t grp [$];
		font_char_t fc;
		int n;
		int p;
		int left;
		for (int k = 0; k < seq_len; k++) begin
			seq[k] = seq_bytes[k];
		end
		n = seq_len + 1;
		seq[seq_len] = code;
		p = 0;
		while (p < n) begin
			left = n - p;
			m = punct_char(seq[p]);
			fc.eot = 1'b0;
			if (m != 8'h00) begin
				fc.code = m;
				p += 1;
			end else if (seq[p] == fcn_pkg::U8_LEAD2 && left >= 2 &&
				seq[p+1] == fcn_pkg::CP_ACUTE) begin
				fc.code = fcn_pkg::CH_APOS;
				p += 2;
			end else if (seq[p] == fcn_pkg::U8_LEAD2 && left == 1 && !eot) begin
				break;
			end else if (seq[p] == fcn_pkg::U8_LEAD3 && left >= 3 &&
				seq[p+1] == fcn_pkg::U8_MID && quote_tail(seq[p+2]) != 8'h00) begin
				fc.code = quote_tail(seq[p+2]);
				p += 3;
			end else if (seq[p] == fcn_pkg::U8_LEAD3 && !eot &&
				(left == 1 || (left == 2 && seq[p+1] == fcn_pkg::U8_MID))) begin
				break;
			end else begin
				fc.code = to_upper(seq[p]);
				p += 1;
			end
			grp = {grp, fc};
		end
		seq_len = 0;
		while (p < n && seq_len < 2) begin
			seq_bytes[seq_len] = seq[p];
			seq_len++;
			p++;
		end
		if (eot) begin
			seq_len = 0;
			if (grp.size() > 0) begin
				grp[grp.size()-1].eot = 1'b1;
			end
		end
		foreach (grp[i]) begin
			font_chars_due = {font_chars_due, grp[i]};
		end
	endtask

	task automatic queue_byte(input logic [7:0] code, input logic eot);
		text_byte_t t;
		t.code = code;
		t.eot = eot;
		text_bytes = {text_bytes, t};
	endtask

	// plain bytes, punctuation, well-formed sequences and broken ones
	task automatic queue_token();
		logic [7:0] tails [6];
		logic [7:0] puncts [8];
		int r;
		tails = '{fcn_pkg::U8_LSQUOTE, fcn_pkg::U8_RSQUOTE, fcn_pkg::U8_LDQUOTE,
			fcn_pkg::U8_RDQUOTE, fcn_pkg::U8_ENDASH, fcn_pkg::U8_EMDASH};
		puncts = '{fcn_pkg::CH_GRAVE, fcn_pkg::CP_LSQUOTE, fcn_pkg::CP_RSQUOTE,
			fcn_pkg::CP_ACUTE, fcn_pkg::CP_LDQUOTE, fcn_pkg::CP_RDQUOTE,
			fcn_pkg::CP_ENDASH, fcn_pkg::CP_EMDASH};
		r = $urandom_range(0, 99);
		if (r < 35) begin
			queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
		end else if (r < 50) begin
			queue_byte(puncts[3'($urandom_range(0, 7))], $urandom_range(0, 9) == 0);
		end else if (r < 62) begin
			queue_byte(fcn_pkg::U8_LEAD2, $urandom_range(0, 39) == 0);
			queue_byte(fcn_pkg::CP_ACUTE, $urandom_range(0, 7) == 0);
		end else if (r < 82) begin
			queue_byte(fcn_pkg::U8_LEAD3, $urandom_range(0, 39) == 0);
			queue_byte(fcn_pkg::U8_MID, $urandom_range(0, 39) == 0);
			queue_byte(tails[3'($urandom_range(0, 5))], $urandom_range(0, 7) == 0);
		end else begin
			if ($urandom_range(0, 1)) begin
				queue_byte(fcn_pkg::U8_LEAD2, 1'b0);
			end else begin
				queue_byte(fcn_pkg::U8_LEAD3, $urandom_range(0, 15) == 0);
				if ($urandom_range(0, 1)) begin
					queue_byte(fcn_pkg::U8_MID, $urandom_range(0, 15) == 0);
				end
			end
			queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
	endtask

	// source side
	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				normalize_byte(in_if.in_byte, in_if.in_last);
				bytes_sent++;
			end
			if (!in_if.valid || in_if.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_if.valid <= 1'b0;
				end else if (text_bytes.size() > 0) begin
					next_byte = text_bytes.pop_front();
					in_if.valid <= 1'b1;
					in_if.in_byte <= next_byte.code;
					in_if.in_last <= next_byte.eot;
					if (text_bytes.size() > CALM_TAIL && !bytes_sent[5] &&
						$urandom_range(0, 4) == 0) begin
						src_gap = $urandom_range(1, 7);
					end
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// sink side
	always @(posedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				chars_seen++;
				if (font_chars_due.size() == 0) begin
					$error("out_char: unexpected transfer, got %h", out_if.out_char);
					errors++;
				end else begin
					due = font_chars_due.pop_front();
					if (out_if.out_char !== due.code) begin
						$error("out_char: expected %h, got %h", due.code, out_if.out_char);
						errors++;
					end
					if (out_if.out_last !== due.eot) begin
						$error("out_last: expected %b, got %b", due.eot, out_if.out_last);
						errors++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
				if (text_bytes.size() > CALM_TAIL && !chars_seen[4] &&
					$urandom_range(0, 5) == 0) begin
					snk_gap = $urandom_range(1, 7);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.in_byte = 8'h00;
		in_if.in_last = 1'b0;
		out_if.ready = 1'b0;

		// case folding bounds
		queue_byte(8'h00, 1'b0);
		queue_byte(fcn_pkg::LOWER_A, 1'b0);
		queue_byte(fcn_pkg::LOWER_Z, 1'b0);
		queue_byte(8'h7B, 1'b0);
		queue_byte(fcn_pkg::LAT_LO, 1'b0);
		queue_byte(fcn_pkg::LAT_LO_END, 1'b0);
		queue_byte(8'hF7, 1'b0);
		queue_byte(fcn_pkg::LAT_HI, 1'b0);
		queue_byte(fcn_pkg::LAT_HI_END, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// single byte punctuation
		queue_byte(fcn_pkg::CH_GRAVE, 1'b0);
		queue_byte(fcn_pkg::CP_LSQUOTE, 1'b0);
		queue_byte(fcn_pkg::CP_RSQUOTE, 1'b0);
		queue_byte(fcn_pkg::CP_ACUTE, 1'b0);
		queue_byte(fcn_pkg::CP_LDQUOTE, 1'b0);
		queue_byte(fcn_pkg::CP_RDQUOTE, 1'b0);
		queue_byte(fcn_pkg::CP_ENDASH, 1'b0);
		queue_byte(fcn_pkg::CP_EMDASH, 1'b0);
		// sequences, a three-char mismatch flush, lead broken by a new lead
		queue_byte(fcn_pkg::U8_LEAD2, 1'b0);
		queue_byte(fcn_pkg::CP_ACUTE, 1'b0);
		queue_byte(fcn_pkg::U8_LEAD3, 1'b0);
		queue_byte(fcn_pkg::U8_MID, 1'b0);
		queue_byte(fcn_pkg::U8_RDQUOTE, 1'b0);
		queue_byte(fcn_pkg::U8_LEAD3, 1'b0);
		queue_byte(fcn_pkg::U8_MID, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(fcn_pkg::U8_LEAD2, 1'b0);
		queue_byte(fcn_pkg::U8_LEAD3, 1'b0);
		queue_byte(fcn_pkg::U8_MID, 1'b0);
		queue_byte(fcn_pkg::U8_ENDASH, 1'b1);
		// incomplete sequences at end of text
		queue_byte(fcn_pkg::U8_LEAD3, 1'b0);
		queue_byte(fcn_pkg::U8_MID, 1'b1);
		queue_byte(fcn_pkg::U8_LEAD2, 1'b1);

		total_bytes = text_bytes.size() + 185;
		while (text_bytes.size() < total_bytes) begin
			queue_token();
		end
		queue_byte(8'h2E, 1'b1);
		total_bytes = text_bytes.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < total_bytes) @(posedge clk);
		while (font_chars_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/fcn_pkg.sv
sv/fcn_if.sv
sv/fcn_front.sv
sv/fcn_queue.sv
sv/fcn_back.sv
sv/font_char_normalizer.sv
sv/fcn_checker.sv
verif/tb_font_char_normalizer.sv
